### rtl/pidl_pkg.sv
// shared types and constants of the positional insert/delete list
`default_nettype none

package pidl_pkg;

  // default list depth
  localparam int LIST_DEPTH_DEF = 64;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VAL_W-1:0] word_t;

endpackage

`default_nettype wire

### rtl/positional_insert_delete_list_top.sv
// top level: operation sequencer, shift engine and result register
`default_nettype none

// Ordered list of up to LIST_DEPTH signed 32-bit words, addressed by
// one-based positions. Insert and delete move the later entries one place
// per cycle through a single-port-write, single-port-read memory. Input is
// taken only when the sequencer is idle; a finished result waits in its own
// output register, so the next item can be taken while the result still
// waits for out_ready.
module positional_insert_delete_list_top
  import pidl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [POS_W-1:0]    position,
  input  logic signed [VAL_W-1:0] value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [VAL_W-1:0] read_value,
  output logic [ST_W-1:0]     status,
  output logic [COUNT_W-1:0]  entry_count,
  output logic                empty_flag
);

  localparam int AW   = $clog2(LIST_DEPTH);
  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOVE  = 3'd1;
  localparam logic [2:0] S_FINAL = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RDONE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] mcnt;
  logic [AW-1:0] src;
  logic [AW-1:0] pend_dst;
  logic          pend;
  logic          is_ins;
  logic [AW-1:0] pos_addr;
  word_t         ins_val;
  word_t         res_value;
  logic [ST_W-1:0] res_status;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  // position checks against the current count
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic            pos_zero;
  logic            ins_bad;
  logic            acc_bad;
  logic            list_full;
  logic [CMPW-1:0] ins_moves;
  logic [CMPW-1:0] del_moves;

  assign pos_x     = CMPW'(position);
  assign cnt_x     = CMPW'(cnt);
  assign pos_zero  = (position == '0);
  assign ins_bad   = pos_zero || (pos_x > cnt_x + CMPW'(1));
  assign acc_bad   = pos_zero || (pos_x > cnt_x);
  assign list_full = (cnt == CW'(LIST_DEPTH));
  assign ins_moves = cnt_x - pos_x + CMPW'(1);
  assign del_moves = cnt_x - pos_x;

  assign in_ready = (state == S_IDLE);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_dst;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = src;
    case (state)
      S_MOVE: begin
        mem_we = pend;
        mem_re = (mcnt != '0);
      end
      S_FINAL: begin
        mem_we    = is_ins;
        mem_waddr = pos_addr;
        mem_wdata = ins_val;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = pos_addr;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos_addr  <= AW'(position - POS_W'(1));
            ins_val   <= value;
            res_value <= '0;
            res_status <= ST_DONE;
            pend      <= 1'b0;
            if (op == OP_INSERT) begin
              is_ins <= 1'b1;
              src    <= AW'(cnt - CW'(1));
              mcnt   <= CW'(ins_moves);
              if (ins_bad) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else if (list_full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_MOVE;
              end
            end else if (op == OP_DELETE) begin
              is_ins <= 1'b0;
              src    <= AW'(position);
              mcnt   <= CW'(del_moves);
              if (acc_bad) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_MOVE;
              end
            end else if (op == OP_READ) begin
              is_ins <= 1'b0;
              if (acc_bad) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end else begin
              is_ins     <= 1'b0;
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end
          end
        end
        S_MOVE: begin
          // one entry moved per cycle: read source, write it in the next cycle
          if (mcnt != '0) begin
            mcnt     <= mcnt - CW'(1);
            pend     <= 1'b1;
            src      <= is_ins ? src - AW'(1) : src + AW'(1);
            pend_dst <= is_ins ? src + AW'(1) : src - AW'(1);
          end else begin
            pend  <= 1'b0;
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          cnt   <= is_ins ? cnt + CW'(1) : cnt - CW'(1);
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_RDONE;
        end
        S_RDONE: begin
          res_value <= mem_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      read_value  <= res_value;
      status      <= res_status;
      entry_count <= COUNT_W'(cnt);
      empty_flag  <= (cnt == '0);
    end
  end

  pidl_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

### rtl/pidl_mem.sv
// entry store: one write port, one read port, registered read data
`default_nettype none

module pidl_mem
  import pidl_pkg::*;
#(
  parameter int DEPTH = LIST_DEPTH_DEF,
  parameter int AW    = $clog2(LIST_DEPTH_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sim/positional_insert_delete_list_tb.sv
// self-checking testbench of the positional insert/delete list top level
`default_nettype none

module tb;
  import pidl_pkg::*;

  // op code with no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int DEPTH       = LIST_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    word_t            val;
  } list_cmd_t;

  typedef struct {
    word_t              rd;
    logic [ST_W-1:0]    st;
    logic [COUNT_W-1:0] cnt;
    logic               empty;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        op = '0;
  logic [POS_W-1:0]       position = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]        status;
  logic [COUNT_W-1:0]     entry_count;
  logic                   empty_flag;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];

  // predictor state
  word_t list_mem[DEPTH];
  int    list_len = 0;

  // generator view of the list length
  int gen_count  = 0;
  bit fill_trend = 1'b1;
  int full_tries = 0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  int  hold_cnt       = 0;
  bit  in_taken       = 1'b0;
  int  errors         = 0;

  positional_insert_delete_list_top #(
    .LIST_DEPTH (DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count),
    .empty_flag  (empty_flag)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // list edit with shifting, one result per command
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op_i,
                                                 input logic [POS_W-1:0] pos_i,
                                                 input word_t val_i);
    list_result_t r;
    int p;
    int i;
    p    = pos_i;
    r.rd = '0;
    r.st = ST_DONE;
    case (op_i)
      OP_INSERT: begin
        if (p == 0 || p > list_len + 1) begin
          r.st = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val_i;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p == 0 || p > list_len) begin
          r.st = ST_RANGE;
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (p == 0 || p > list_len) r.st = ST_RANGE;
        else r.rd = list_mem[p-1];
      end
      default: begin
        r.st = ST_RANGE;
      end
    endcase
    r.cnt   = list_len[COUNT_W-1:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  // queue one command and track the length it leaves behind
  task automatic push_cmd(input logic [OP_W-1:0] c_op, input int c_pos, input word_t c_val);
    list_cmd_t c;
    c.op  = c_op;
    c.pos = c_pos[POS_W-1:0];
    c.val = c_val;
    pending_cmds.push_back(c);
    if (c_op == OP_INSERT && c_pos >= 1 && c_pos <= gen_count + 1) begin
      if (gen_count == DEPTH) full_tries++;
      else gen_count++;
    end else if (c_op == OP_DELETE && c_pos >= 1 && c_pos <= gen_count) begin
      gen_count--;
    end
    // sweep between filling up and draining out
    if (fill_trend && full_tries >= 3) begin
      fill_trend = 1'b0;
      full_tries = 0;
    end else if (!fill_trend && gen_count == 0) begin
      fill_trend = 1'b1;
    end
  endtask

  // random commands, mostly at valid positions
  task automatic add_random_cmds(input int n);
    int k;
    int r;
    int c_pos;
    int hi;
    logic [OP_W-1:0] c_op;
    word_t c_val;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) c_op = OP_UNUSED;
      else if (fill_trend) c_op = (r < 62) ? OP_INSERT : (r < 82) ? OP_DELETE : OP_READ;
      else c_op = (r < 22) ? OP_INSERT : (r < 72) ? OP_DELETE : OP_READ;
      hi = (c_op == OP_INSERT) ? gen_count + 1 : gen_count;
      if (hi > DEPTH) hi = DEPTH;
      if (hi < 1) hi = 1;
      if (c_op == OP_UNUSED || $urandom_range(0, 9) == 0) c_pos = $urandom_range(0, DEPTH);
      else c_pos = $urandom_range(1, hi);
      case ($urandom_range(0, 9))
        0: c_val = 32'h8000_0000;
        1: c_val = 32'h7fff_ffff;
        2: c_val = '0;
        3: c_val = '1;
        default: c_val = $urandom;
      endcase
      push_cmd(c_op, c_pos, c_val);
    end
  endtask

  // sender: new command at the falling edge once the last one is taken
  always @(negedge clk) begin
    list_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        op       <= c.op;
        position <= c.pos;
        value    <= c.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // input transfer: predict, result transfer: compare
  always @(posedge clk) begin
    list_result_t e;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        expected_results.push_back(apply_list_op(op, position, value));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no result expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (read_value !== e.rd) begin
            $error("read_value: expected %0d, got %0d", e.rd, read_value);
            errors++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status);
            errors++;
          end
          if (entry_count !== e.cnt) begin
            $error("entry_count: expected %0d, got %0d", e.cnt, entry_count);
            errors++;
          end
          if (empty_flag !== e.empty) begin
            $error("empty_flag: expected %0d, got %0d", e.empty, empty_flag);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // phases of stimulus
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, bad positions, edges of the list and of the value
    push_cmd(OP_READ, 1, 32'sd5);
    push_cmd(OP_DELETE, 1, 32'sd0);
    push_cmd(OP_INSERT, 0, 32'sd1);
    push_cmd(OP_INSERT, 2, 32'sd1);
    push_cmd(OP_INSERT, 1, 32'h7fff_ffff);
    push_cmd(OP_INSERT, 2, 32'h8000_0000);
    push_cmd(OP_INSERT, 1, -32'sd1);
    push_cmd(OP_INSERT, 2, 32'sd0);
    push_cmd(OP_INSERT, 5, 32'h5555_aaaa);
    push_cmd(OP_INSERT, 7, 32'sd3);
    push_cmd(OP_READ, 1, 32'sd0);
    push_cmd(OP_READ, 2, 32'sd0);
    push_cmd(OP_READ, 3, 32'sd0);
    push_cmd(OP_READ, 5, 32'sd0);
    push_cmd(OP_READ, 6, 32'sd0);
    push_cmd(OP_READ, 0, 32'sd0);
    push_cmd(OP_UNUSED, DEPTH, 32'h7fff_ffff);
    push_cmd(OP_INSERT, DEPTH, 32'sd9);
    push_cmd(OP_DELETE, 0, 32'sd0);
    push_cmd(OP_DELETE, 6, 32'sd0);
    push_cmd(OP_DELETE, 3, 32'sd0);
    push_cmd(OP_DELETE, 4, 32'sd0);
    push_cmd(OP_DELETE, 1, 32'sd0);
    push_cmd(OP_READ, 2, 32'sd0);

    // random phases with different idling
    add_random_cmds(210);
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    send_idle_pct = 46;
    add_random_cmds(210);
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    add_random_cmds(210);
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    add_random_cmds(160);
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_cmds(50);
    hold_req = 1'b1;

    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
